// File: hw/rtl/wir_pkg.sv
// ----------------------------------------------------------------------------
// wir_pkg
// Shared constants and types for the interpolating wavetable reader.
// ----------------------------------------------------------------------------
package wir_pkg;

  // table and field geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int PHASE_W     = 32;
  localparam int INDEX_W     = 16;
  localparam int LEN_W       = 11;
  localparam int MODE_W      = 2;

  // derived widths
  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int INT_W    = PHASE_W - FRAC_BITS;
  localparam int CNT_W    = $clog2(INT_W);
  localparam int PROD_W   = SAMPLE_BITS + FRAC_BITS + 2;

  // item opcodes
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_INTERP = 2'd2
  } mode_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MUL,
    ST_PLAIN,
    ST_OUT
  } state_e;

endpackage

// File: hw/rtl/wir_ram.sv
// ----------------------------------------------------------------------------
// wir_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/wavetable_interpolating_reader.sv
// ----------------------------------------------------------------------------
// wavetable_interpolating_reader
// Sample table with plain reads and linearly interpolated reads at a phase.
// ----------------------------------------------------------------------------
// A write word gives no result and leaves the block ready for the next word.
// A plain read passes through ST_PLAIN to ST_OUT; an out-of-range read, or
// any read at length zero, goes straight from ST_IDLE to ST_OUT. An
// interpolated read first wraps the phase integer part modulo the table
// length, bit-serially in ST_DIV, one quotient bit per cycle. ST_FIX then
// folds a negative phase. The two reads from the single read port of the
// table run through ST_RD1, ST_RD2 and ST_RD3, with the multiply in the last
// of them. ST_MUL does the final add, and ST_OUT hands the word to the
// output register. One word is worked on at a time; a new word is taken while
// the previous result still waits in the output register. A stalled receiver
// holds the block in ST_OUT until the output register is free. The table
// holds undefined data after reset, so only written entries may be read.
module wavetable_interpolating_reader
  import wir_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [LEN_W-1:0]              cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [MODE_W-1:0]             mode_i,
  input  logic [INDEX_W-1:0]            index_i,
  input  logic signed [PHASE_W-1:0]     phase_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          out_of_range_o
);

  state_e state_q, state_d;

  logic [LEN_W-1:0]        len_q;
  logic [LEN_W-1:0]        len_eff;
  logic                    neg_q, neg_d;
  logic [INT_W-1:0]        quo_q, quo_d;
  logic [FRAC_BITS-1:0]    lo_q, lo_d;
  logic [ADDR_W-1:0]       rem_q, rem_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [ADDR_W-1:0]       i1_q, i1_d;
  logic [FRAC_BITS-1:0]    frac_q, frac_d;
  logic [SAMPLE_BITS-1:0]  d1_q, d1_d;
  logic [SAMPLE_BITS-1:0]  step_q, step_d;
  logic [SAMPLE_BITS-1:0]  res_q, res_d;
  logic                    oor_q, oor_d;
  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]  sample_out_q, sample_out_d;
  logic                    out_oor_q, out_oor_d;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [SAMPLE_BITS-1:0]  ram_rdata;

  logic                    idx_in_range;
  logic [PHASE_W-1:0]      phase_mag;
  logic [LEN_W-1:0]        trial;
  logic [LEN_W-1:0]        i2_wide;
  logic [ADDR_W-1:0]       i2;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [PROD_W-1:0]    prod;

  // sample table
  wir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (index_i[ADDR_W-1:0]),
    .wdata_i (sample_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // length register, clamped to the table depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  assign len_eff = (len_q > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : len_q;

  // shared datapath terms
  assign idx_in_range = index_i < INDEX_W'(len_eff);
  assign phase_mag    = phase_i[PHASE_W-1] ? (~phase_i + 1'b1) : phase_i;
  assign trial        = {rem_q, quo_q[INT_W-1]};
  assign i2_wide      = LEN_W'(i1_q) + 1'b1;
  assign i2           = (i2_wide >= len_eff) ? '0 : i2_wide[ADDR_W-1:0];
  assign diff         = $signed({ram_rdata[SAMPLE_BITS-1], ram_rdata})
                      - $signed({d1_q[SAMPLE_BITS-1], d1_q});
  assign prod         = diff * $signed({1'b0, frac_q});

  // sequencer: next state and datapath updates
  always_comb begin
    state_d      = state_q;
    neg_d        = neg_q;
    quo_d        = quo_q;
    lo_d         = lo_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    i1_d         = i1_q;
    frac_d       = frac_q;
    d1_d         = d1_q;
    step_d       = step_q;
    res_d        = res_q;
    oor_d        = oor_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    sample_out_d = sample_out_q;
    out_oor_d    = out_oor_q;
    ram_we       = 1'b0;
    ram_raddr    = index_i[ADDR_W-1:0];
    in_ready_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (mode_e'(mode_i))
            MODE_WRITE: begin
              ram_we = idx_in_range;
            end
            MODE_READ: begin
              if (idx_in_range) begin
                state_d = ST_PLAIN;
              end else begin
                res_d   = '0;
                oor_d   = 1'b1;
                state_d = ST_OUT;
              end
            end
            MODE_INTERP: begin
              if (len_eff == '0) begin
                res_d   = '0;
                oor_d   = 1'b1;
                state_d = ST_OUT;
              end else begin
                neg_d   = phase_i[PHASE_W-1];
                quo_d   = phase_mag[PHASE_W-1:FRAC_BITS];
                lo_d    = phase_mag[FRAC_BITS-1:0];
                rem_d   = '0;
                cnt_d   = '0;
                state_d = ST_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // one quotient bit per cycle, keeping only the remainder
      ST_DIV: begin
        if (trial >= len_eff) begin
          rem_d = ADDR_W'(trial - len_eff);
        end else begin
          rem_d = ADDR_W'(trial);
        end
        quo_d = quo_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(INT_W - 1)) begin
          state_d = ST_FIX;
        end
      end
      // fold a negative phase back into the table span
      ST_FIX: begin
        if (neg_q && (lo_q != '0)) begin
          i1_d   = ADDR_W'(len_eff - 1'b1 - LEN_W'(rem_q));
          frac_d = ~lo_q + 1'b1;
        end else if (neg_q && (rem_q != '0)) begin
          i1_d   = ADDR_W'(len_eff - LEN_W'(rem_q));
          frac_d = '0;
        end else begin
          i1_d   = rem_q;
          frac_d = lo_q;
        end
        state_d = ST_RD1;
      end
      ST_RD1: begin
        ram_raddr = i1_q;
        state_d   = ST_RD2;
      end
      ST_RD2: begin
        d1_d      = ram_rdata;
        ram_raddr = i2;
        state_d   = ST_RD3;
      end
      // slope times fraction, floored by the arithmetic shift
      ST_RD3: begin
        step_d  = prod[FRAC_BITS +: SAMPLE_BITS];
        state_d = ST_MUL;
      end
      ST_MUL: begin
        res_d   = d1_q + step_q;
        oor_d   = 1'b0;
        state_d = ST_OUT;
      end
      ST_PLAIN: begin
        res_d   = ram_rdata;
        oor_d   = 1'b0;
        state_d = ST_OUT;
      end
      // hand the word to the output register once it is free
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          sample_out_d = res_q;
          out_oor_d    = oor_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    neg_q        <= neg_d;
    quo_q        <= quo_d;
    lo_q         <= lo_d;
    rem_q        <= rem_d;
    i1_q         <= i1_d;
    frac_q       <= frac_d;
    d1_q         <= d1_d;
    step_q       <= step_d;
    res_q        <= res_d;
    oor_q        <= oor_d;
    sample_out_q <= sample_out_d;
    out_oor_q    <= out_oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sample_out_q;
  assign out_of_range_o = out_oor_q;

endmodule
